>>> rtl/vru_pkg.sv
// shared types, constants and rounding helper for the vector reflection unit
package vru_pkg;

   localparam int UnitBits  = 30;
   localparam int UnitWidth = UnitBits + 2;
   localparam int SqrtBits  = 64;
   localparam int RootBits  = UnitBits + 1;
   localparam int RemBits   = 2 * UnitBits + 2;
   localparam int QuotBits  = UnitBits + 1;
   localparam int WideBits  = 72;

   typedef enum logic [1:0] {
      STATUS_REFLECTED = 2'd0,
      STATUS_AWAY      = 2'd1,
      STATUS_ZERO      = 2'd2
   } status_type;

   typedef logic [UnitBits-1:0] mag_type;

   typedef struct packed {
      logic       valid;
      logic       zero;
      logic [2:0] sign;
   } tag_type;

   typedef struct packed {
      logic [SqrtBits-1:0] x;
      logic [SqrtBits-1:0] res;
      mag_type [2:0]       mag;
      tag_type             tag;
   } root_type;

   typedef struct packed {
      logic [2:0][RemBits-1:0]  rem;
      logic [2:0][QuotBits-1:0] quot;
      logic [RootBits-1:0]      len;
      tag_type                  tag;
   } quot_type;

   // shift right with rounding half away from zero
   function automatic logic signed [WideBits-1:0] round_shift(
      input logic signed [WideBits-1:0] v,
      input int unsigned s
   );
      logic                neg;
      logic [WideBits-1:0] m;
      begin
         neg = v[WideBits-1];
         m   = neg ? WideBits'(-v) : WideBits'(v);
         if (s != 0) begin
            m = (m + (WideBits'(1) << (s - 1))) >> s;
         end
         return neg ? -$signed(m) : $signed(m);
      end
   endfunction

endpackage

>>> rtl/vru_root_cell.sv
// one bit of the pipelined integer square root
module vru_root_cell
   import vru_pkg::*;
#(
   parameter int LEVEL = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  root_type prev,
   output root_type cell_ff
);

   root_type cell_in;

   always_comb begin
      logic [SqrtBits-1:0] bitval;
      logic [SqrtBits-1:0] trial;
      bitval  = SqrtBits'(1) << (2 * LEVEL);
      trial   = prev.res + bitval;
      cell_in = prev;
      if (prev.x >= trial) begin
         cell_in.x   = prev.x - trial;
         cell_in.res = (prev.res >> 1) + bitval;
      end else begin
         cell_in.res = prev.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (reset) begin
         cell_ff.tag.valid <= 1'b0;
      end
   end

endmodule

>>> rtl/vru_div_cell.sv
// one quotient bit of the pipelined divider, three lanes sharing a divisor
module vru_div_cell
   import vru_pkg::*;
#(
   parameter int LEVEL = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  quot_type prev,
   output quot_type cell_ff
);

   quot_type cell_in;

   always_comb begin
      logic [RemBits-1:0] trial;
      trial   = RemBits'(prev.len) << LEVEL;
      cell_in = prev;
      for (int i = 0; i < 3; i++) begin
         if (prev.rem[i] >= trial) begin
            cell_in.rem[i]         = prev.rem[i] - trial;
            cell_in.quot[i][LEVEL] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (reset) begin
         cell_ff.tag.valid <= 1'b0;
      end
   end

endmodule

>>> rtl/vru_norm.sv
// normalizes a three component vector to Q.30 unit components
module vru_norm
   import vru_pkg::*;
#(
   parameter int INPUT_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [2:0][INPUT_WIDTH-1:0]      comp,
   output logic                             out_valid,
   output logic                             out_zero,
   output logic [2:0][UnitWidth-1:0]        unit
);

   localparam int BlenBits = $clog2(INPUT_WIDTH + 1);

   logic [2:0][INPUT_WIDTH-1:0] a_mag_ff, b_mag_ff;
   tag_type                     a_tag_ff, b_tag_ff, c_tag_ff, d_tag_ff;
   logic [BlenBits-1:0]         b_len_ff;
   mag_type [2:0]               c_mag_ff, d_mag_ff;
   logic [2:0][2*UnitBits-1:0]  d_sq_ff;
   root_type                    root_chain [RootBits+1];
   quot_type                    quot_chain [QuotBits+1];

   logic [INPUT_WIDTH-1:0]      mx;
   logic [BlenBits-1:0]         blen;

   always_comb begin
      mx = a_mag_ff[0];
      if (a_mag_ff[1] > mx) mx = a_mag_ff[1];
      if (a_mag_ff[2] > mx) mx = a_mag_ff[2];
      blen = '0;
      for (int i = 0; i < INPUT_WIDTH; i++) begin
         if (mx[i]) blen = BlenBits'(i + 1);
      end
   end

   always_ff @(posedge clock) begin
      logic [INPUT_WIDTH+UnitBits-1:0] wide;
      // stage a: magnitudes and signs
      for (int i = 0; i < 3; i++) begin
         a_mag_ff[i]    <= comp[i][INPUT_WIDTH-1] ? -comp[i] : comp[i];
         a_tag_ff.sign[i] <= comp[i][INPUT_WIDTH-1];
      end
      a_tag_ff.valid <= in_valid;
      a_tag_ff.zero  <= 1'b0;
      // stage b: bit length of the largest magnitude
      b_mag_ff      <= a_mag_ff;
      b_len_ff      <= blen;
      b_tag_ff      <= a_tag_ff;
      b_tag_ff.zero <= (mx == '0);
      // stage c: rescale so the largest magnitude has UnitBits bits
      for (int i = 0; i < 3; i++) begin
         wide        = {b_mag_ff[i], UnitBits'(0)} >> b_len_ff;
         c_mag_ff[i] <= wide[UnitBits-1:0];
      end
      c_tag_ff <= b_tag_ff;
      // stage d: squares
      for (int i = 0; i < 3; i++) begin
         d_sq_ff[i] <= c_mag_ff[i] * c_mag_ff[i];
      end
      d_mag_ff <= c_mag_ff;
      d_tag_ff <= c_tag_ff;
      // stage e: sum of squares enters the root chain
      root_chain[0].x   <= SqrtBits'(d_sq_ff[0]) + SqrtBits'(d_sq_ff[1])
                           + SqrtBits'(d_sq_ff[2]);
      root_chain[0].res <= '0;
      root_chain[0].mag <= d_mag_ff;
      root_chain[0].tag <= d_tag_ff;
      if (reset) begin
         a_tag_ff.valid          <= 1'b0;
         b_tag_ff.valid          <= 1'b0;
         c_tag_ff.valid          <= 1'b0;
         d_tag_ff.valid          <= 1'b0;
         root_chain[0].tag.valid <= 1'b0;
      end
   end

   for (genvar g = 0; g < RootBits; g++) begin : g_root
      vru_root_cell #(
         .LEVEL(RootBits - 1 - g)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .prev   (root_chain[g]),
         .cell_ff(root_chain[g+1])
      );
   end

   // dividend with half the divisor added for rounding
   always_ff @(posedge clock) begin
      logic [RootBits-1:0] len;
      len = root_chain[RootBits].res[RootBits-1:0];
      for (int i = 0; i < 3; i++) begin
         quot_chain[0].rem[i]  <= RemBits'({root_chain[RootBits].mag[i], UnitBits'(0)})
                                  + RemBits'(len >> 1);
         quot_chain[0].quot[i] <= '0;
      end
      quot_chain[0].len <= len;
      quot_chain[0].tag <= root_chain[RootBits].tag;
      if (reset) begin
         quot_chain[0].tag.valid <= 1'b0;
      end
   end

   for (genvar g = 0; g < QuotBits; g++) begin : g_div
      vru_div_cell #(
         .LEVEL(QuotBits - 1 - g)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .prev   (quot_chain[g]),
         .cell_ff(quot_chain[g+1])
      );
   end

   always_ff @(posedge clock) begin
      logic [UnitWidth-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q       = UnitWidth'(quot_chain[QuotBits].quot[i]);
         unit[i] <= quot_chain[QuotBits].tag.sign[i] ? -q : q;
      end
      out_zero  <= quot_chain[QuotBits].tag.zero;
      out_valid <= quot_chain[QuotBits].tag.valid;
      if (reset) begin
         out_valid <= 1'b0;
      end
   end

endmodule

>>> rtl/vector_reflection_unit.sv
// Reflects a direction about a surface normal, both normalized first. Fully
// pipelined: busy stays low and a new transaction may start every clock. The
// result strobe rsp_valid follows the accepting edge through the two normalizers
// (a 31-cell square-root chain and a 31-cell divider chain, one bit per cell)
// and then the dot product and reflection stages. The receiver cannot stall;
// each result is on the rsp_ ports for one cycle only.
module vector_reflection_unit
   import vru_pkg::*;
#(
   parameter int INPUT_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [INPUT_WIDTH-1:0] req_dir_x,
   input  logic signed [INPUT_WIDTH-1:0] req_dir_y,
   input  logic signed [INPUT_WIDTH-1:0] req_dir_z,
   input  logic signed [INPUT_WIDTH-1:0] req_norm_x,
   input  logic signed [INPUT_WIDTH-1:0] req_norm_y,
   input  logic signed [INPUT_WIDTH-1:0] req_norm_z,
   output logic                         rsp_valid,
   output logic signed [FRACTION_BITS+1:0] rsp_refl_x,
   output logic signed [FRACTION_BITS+1:0] rsp_refl_y,
   output logic signed [FRACTION_BITS+1:0] rsp_refl_z,
   output logic [1:0]                   rsp_status
);

   localparam int OutWidth = FRACTION_BITS + 2;
   localparam int DotBits  = 64;
   localparam int D30Bits  = 34;
   localparam int ProdBits = D30Bits + UnitWidth;
   localparam int RBits    = 40;
   localparam logic signed [WideBits-1:0] Lim = WideBits'(1) <<< FRACTION_BITS;

   logic                        accept;
   logic                        dn_valid, dn_zero, nn_valid, nn_zero;
   logic [2:0][UnitWidth-1:0]   du, nu;

   logic                        p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic                        p5_valid_ff;
   logic                        p1_zero_ff, p2_zero_ff;
   logic signed [DotBits-1:0]   p1_prod_ff [3];
   logic [2:0][UnitWidth-1:0]   p1_du_ff, p1_nu_ff, p2_du_ff, p2_nu_ff;
   logic [2:0][UnitWidth-1:0]   p3_du_ff, p3_nu_ff, p4_du_ff;
   logic signed [DotBits-1:0]   p2_dot_ff;
   logic signed [D30Bits-1:0]   p3_d30_ff;
   status_type                  p3_status_ff, p4_status_ff, p5_status_ff;
   logic signed [ProdBits-1:0]  p4_prod_ff [3];
   logic signed [RBits-1:0]     p5_r_ff [3];
   logic signed [OutWidth-1:0]  refl [3];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   vru_norm #(
      .INPUT_WIDTH(INPUT_WIDTH)
   ) u_dir_norm (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .comp     ({req_dir_z, req_dir_y, req_dir_x}),
      .out_valid(dn_valid),
      .out_zero (dn_zero),
      .unit     (du)
   );

   vru_norm #(
      .INPUT_WIDTH(INPUT_WIDTH)
   ) u_norm_norm (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .comp     ({req_norm_z, req_norm_y, req_norm_x}),
      .out_valid(nn_valid),
      .out_zero (nn_zero),
      .unit     (nu)
   );

   always_comb begin
      logic signed [WideBits-1:0] o;
      for (int i = 0; i < 3; i++) begin
         o = round_shift(WideBits'(p5_r_ff[i]), UnitBits - FRACTION_BITS);
         if (o > Lim) o = Lim;
         if (o < -Lim) o = -Lim;
         refl[i] = (p5_status_ff == STATUS_REFLECTED) ? o[OutWidth-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [WideBits-1:0] t;
      logic signed [WideBits-1:0] dr;
      // products of the unit components
      for (int i = 0; i < 3; i++) begin
         p1_prod_ff[i] <= $signed(du[i]) * $signed(nu[i]);
      end
      p1_du_ff    <= du;
      p1_nu_ff    <= nu;
      p1_zero_ff  <= dn_zero || nn_zero;
      p1_valid_ff <= dn_valid && nn_valid;
      // dot product
      p2_dot_ff   <= p1_prod_ff[0] + p1_prod_ff[1] + p1_prod_ff[2];
      p2_du_ff    <= p1_du_ff;
      p2_nu_ff    <= p1_nu_ff;
      p2_zero_ff  <= p1_zero_ff;
      p2_valid_ff <= p1_valid_ff;
      // facing test and dot product back to Q.30
      dr = round_shift(WideBits'(p2_dot_ff), UnitBits);
      p3_d30_ff <= dr[D30Bits-1:0];
      if (p2_zero_ff) begin
         p3_status_ff <= STATUS_ZERO;
      end else if (!p2_dot_ff[DotBits-1]) begin
         p3_status_ff <= STATUS_AWAY;
      end else begin
         p3_status_ff <= STATUS_REFLECTED;
      end
      p3_du_ff    <= p2_du_ff;
      p3_nu_ff    <= p2_nu_ff;
      p3_valid_ff <= p2_valid_ff;
      // d times the normal
      for (int i = 0; i < 3; i++) begin
         p4_prod_ff[i] <= p3_d30_ff * $signed(p3_nu_ff[i]);
      end
      p4_du_ff     <= p3_du_ff;
      p4_status_ff <= p3_status_ff;
      p4_valid_ff  <= p3_valid_ff;
      // subtract twice the projection
      for (int i = 0; i < 3; i++) begin
         t = round_shift(WideBits'(p4_prod_ff[i]) <<< 1, UnitBits);
         dr = WideBits'($signed(p4_du_ff[i])) - t;
         p5_r_ff[i] <= dr[RBits-1:0];
      end
      p5_status_ff <= p4_status_ff;
      p5_valid_ff  <= p4_valid_ff;
      // result registers
      rsp_refl_x <= refl[0];
      rsp_refl_y <= refl[1];
      rsp_refl_z <= refl[2];
      rsp_status <= p5_status_ff;
      rsp_valid  <= p5_valid_ff;
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end
   end

endmodule
